// ----- rtl/asne_pkg.sv -----
package asne_pkg;

   localparam int unsigned VEL_FRAC_BITS = 24;

   localparam int unsigned ADDR_W = 5;
   localparam logic [2:0] REG_GAMMA   = 3'd0;
   localparam logic [2:0] REG_BETA    = 3'd1;
   localparam logic [2:0] REG_DT      = 3'd2;
   localparam logic [2:0] REG_INIT_X  = 3'd3;
   localparam logic [2:0] REG_INIT_Y  = 3'd4;
   localparam logic [2:0] REG_INIT_Z  = 3'd5;

   localparam logic [31:0] GAMMA_RST  = 32'd16777216;
   localparam logic [31:0] BETA_RST   = 32'd16777216;
   localparam logic [31:0] DT_RST     = 32'd42949673;
   localparam logic signed [31:0] INIT_X_RST = 32'sd0;
   localparam logic signed [31:0] INIT_Y_RST = 32'sd0;
   localparam logic signed [31:0] INIT_Z_RST = 32'sd1073741824;

   // Right shifts applied to the product after it has been moved up by eight bits.
   localparam int unsigned SH_VV     = 2 * VEL_FRAC_BITS - 16;
   localparam int unsigned SH_LEAK   = 32;
   localparam int unsigned SH_STEP   = 40;
   localparam int unsigned SH_PROJ   = 38;
   localparam int unsigned SH_GAIN   = 40;
   localparam int unsigned SH_CORR   = 26;
   localparam int unsigned SH_SQUARE = 8;

   localparam logic [63:0] LIM48 = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] LIM62 = 64'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM63 = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      MUL_VV,
      MUL_LEAK,
      MUL_STEP,
      MUL_PROJ,
      MUL_GAIN,
      MUL_CORR,
      MUL_SQUARE
   } mul_op_type;

endpackage

// ----- rtl/asne_mul.sv -----
module asne_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [63:0]     op_a,
   input  logic signed [32:0]     op_b,
   input  asne_pkg::mul_op_type   op,
   output logic                   done,
   output logic signed [63:0]     result
);
   import asne_pkg::*;

   logic [63:0] ua_ff, ua_in;
   logic [31:0] ub_ff, ub_in;
   logic        neg_ff, neg_in;
   mul_op_type  op_ff, op_in;
   logic [63:0] p0_ff, p0_in, p1_ff, p1_in;
   logic [2:0]  stage_ff, stage_in;
   logic        done_ff, done_in;
   logic [63:0] res_ff, res_in;

   logic [63:0]  mag_a;
   logic [32:0]  mag_b;
   logic [95:0]  prod;
   logic [103:0] ext, shifted;
   logic [63:0]  lim_base, lim, mag_v;

   always_comb begin
      mag_a = op_a[63] ? (64'd0 - op_a) : op_a;
      mag_b = op_b[32] ? (33'd0 - op_b) : op_b;
      ua_in  = start ? mag_a : ua_ff;
      ub_in  = start ? mag_b[31:0] : ub_ff;
      neg_in = start ? (op_a[63] ^ op_b[32]) : neg_ff;
      op_in  = start ? op : op_ff;
      stage_in = {stage_ff[1:0], start};
      p0_in = stage_ff[0] ? ua_ff[31:0] * ub_ff : p0_ff;
      p1_in = stage_ff[1] ? ua_ff[63:32] * ub_ff : p1_ff;

      prod = {32'd0, p0_ff} + {p1_ff, 32'd0};
      ext  = {prod, 8'd0};
      case (op_ff)
         MUL_VV: begin
            shifted = ext >> SH_VV;
            lim_base = LIM48;
         end
         MUL_LEAK: begin
            shifted = ext >> SH_LEAK;
            lim_base = LIM63;
         end
         MUL_STEP: begin
            shifted = ext >> SH_STEP;
            lim_base = LIM48;
         end
         MUL_PROJ: begin
            shifted = ext >> SH_PROJ;
            lim_base = LIM63;
         end
         MUL_GAIN: begin
            shifted = ext >> SH_GAIN;
            lim_base = LIM63;
         end
         MUL_CORR: begin
            shifted = ext >> SH_CORR;
            lim_base = LIM62;
         end
         default: begin
            shifted = ext >> SH_SQUARE;
            lim_base = LIM63;
         end
      endcase
      lim   = lim_base + {63'd0, neg_ff};
      mag_v = (shifted > {40'd0, lim}) ? lim : shifted[63:0];
      res_in  = stage_ff[2] ? (neg_ff ? (64'd0 - mag_v) : mag_v) : res_ff;
      done_in = stage_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 3'd0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      op_ff  <= op_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ----- rtl/asne_sqrt.sv -----
module asne_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import asne_pkg::*;

   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   always_comb begin
      trial   = r_ff + bit_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         r_in    = 64'd0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

// ----- rtl/asne_div.sv -----
module asne_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import asne_pkg::*;

   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      trial   = {rem_ff, num_ff[63]};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = 32'd0;
         den_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            num_in = {num_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            num_in = {num_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

// ----- rtl/adaptive_surface_normal_estimator_unit.sv -----
// Adaptive surface normal estimator.
// Input words arrive on the req_ channel (req_valid, req_stall): a restart command or a
// velocity sample. Each accepted word yields exactly one result word on the rsp_ channel
// (rsp_valid, rsp_stall) carrying the normal estimate after that word and the zero-length
// flag. The block handles one word at a time; req_stall is high from acceptance until the
// result word has been taken.
// An update runs 49 operations through one shared multiplier, the last three (the squares)
// after a normalising shift of one bit per cycle (up to 31 bits), then a square root and
// three divisions. A zero-length update skips the shift, squares, root and divisions.
// A restart word gives its result on the following cycle.
// The result is held stable for as long as rsp_stall is high, and no new word is taken
// until it has gone.
// Synchronous reset loads the register defaults, clears the outer-product matrix and loads
// the default initial normal. The user writes the gains and the initial normal over the
// APB-style port only while the block is idle; the block itself does not enforce this.
module adaptive_surface_normal_estimator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic signed [31:0]            req_vel_x,
   input  logic signed [31:0]            req_vel_y,
   input  logic signed [31:0]            req_vel_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_normal_x,
   output logic signed [31:0]            rsp_normal_y,
   output logic signed [31:0]            rsp_normal_z,
   output logic                          rsp_zero_norm,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [asne_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import asne_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE   = 15'h0001,
      S_VV     = 15'h0002,
      S_LEAK   = 15'h0004,
      S_STEP   = 15'h0008,
      S_WACC   = 15'h0010,
      S_SACC   = 15'h0020,
      S_GAIN   = 15'h0040,
      S_PROJ   = 15'h0080,
      S_CORR   = 15'h0100,
      S_MAG    = 15'h0200,
      S_SHIFT  = 15'h0400,
      S_SQUARE = 15'h0800,
      S_ROOT   = 15'h1000,
      S_DIVIDE = 15'h2000,
      S_OUT    = 15'h4000
   } state_type;

   state_type state_ff, state_in;
   logic      wait_ff, wait_in;

   logic [31:0]        gamma_ff, gamma_in, beta_ff, beta_in, dt_ff, dt_in;
   logic signed [31:0] init_ff [3];
   logic signed [31:0] init_in [3];

   logic signed [47:0] l_ff [9];
   logic signed [47:0] l_in [9];
   logic signed [31:0] n_ff [3];
   logic signed [31:0] n_in [3];
   logic               zero_ff, zero_in;

   logic signed [31:0] vrow_ff [3];
   logic signed [31:0] vrow_in [3];
   logic signed [31:0] vcol_ff [3];
   logic signed [31:0] vcol_in [3];
   logic signed [63:0] w_ff [3];
   logic signed [63:0] w_in [3];
   logic signed [63:0] m_ff [3];
   logic signed [63:0] m_in [3];
   logic [63:0]        a_ff [3];
   logic [63:0]        a_in [3];
   logic [63:0]        acc_ff, acc_in;
   logic signed [63:0] tmp_ff, tmp_in, prod_ff, prod_in, s_ff, s_in;
   logic [31:0]        g_ff, g_in, r_ff, r_in;
   logic [1:0]         i_ff, i_in, j_ff, j_in;

   logic [3:0]         kidx;
   logic [1:0]         nsel;
   logic signed [31:0] n_rd;
   logic signed [63:0] l_rd;
   logic signed [63:0] l_sum;
   logic [63:0]        acc_sum;
   logic               cfg_wr;
   logic               any_high, any_top;
   logic [31:0]        q_sat;

   logic               mul_start, mul_done;
   logic signed [63:0] mul_a, mul_res;
   logic signed [32:0] mul_b;
   mul_op_type         mul_op;
   logic               sqrt_start, sqrt_done;
   logic [31:0]        sqrt_root;
   logic               div_start, div_done;
   logic [63:0]        div_num, div_q;

   function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
      logic signed [47:0] y;
      if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
         y = 48'sh7FFF_FFFF_FFFF;
      end else if (x < -64'sh0000_8000_0000_0000) begin
         y = 48'sh8000_0000_0000;
      end else begin
         y = x[47:0];
      end
      return y;
   endfunction

   asne_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .op     (mul_op),
      .done   (mul_done),
      .result (mul_res)
   );

   asne_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   asne_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (r_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign kidx = {2'd0, i_ff} + {1'b0, i_ff, 1'b0} + {2'd0, j_ff};
   assign nsel = (state_ff == S_WACC) ? j_ff : i_ff;
   assign n_rd = n_ff[nsel];
   assign l_rd = {{16{l_ff[kidx][47]}}, l_ff[kidx]};
   assign div_num = a_ff[i_ff] << 30;
   assign cfg_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;

   always_comb begin
      case (paddr[4:2])
         REG_GAMMA:  prdata = gamma_ff;
         REG_BETA:   prdata = beta_ff;
         REG_DT:     prdata = dt_ff;
         REG_INIT_X: prdata = init_ff[0];
         REG_INIT_Y: prdata = init_ff[1];
         REG_INIT_Z: prdata = init_ff[2];
         default:    prdata = 32'd0;
      endcase
   end

   always_comb begin
      gamma_in = gamma_ff;
      beta_in  = beta_ff;
      dt_in    = dt_ff;
      init_in  = init_ff;
      if (cfg_wr) begin
         case (paddr[4:2])
            REG_GAMMA:  gamma_in   = pwdata;
            REG_BETA:   beta_in    = pwdata;
            REG_DT:     dt_in      = pwdata;
            REG_INIT_X: init_in[0] = pwdata;
            REG_INIT_Y: init_in[1] = pwdata;
            REG_INIT_Z: init_in[2] = pwdata;
            default:    gamma_in   = gamma_ff;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a  = l_rd;
      mul_b  = {n_rd[31], n_rd};
      mul_op = MUL_PROJ;
      case (state_ff)
         S_VV: begin
            mul_a  = {{32{vrow_ff[i_ff][31]}}, vrow_ff[i_ff]};
            mul_b  = {vcol_ff[j_ff][31], vcol_ff[j_ff]};
            mul_op = MUL_VV;
         end
         S_LEAK: begin
            mul_b  = {1'b0, beta_ff};
            mul_op = MUL_LEAK;
         end
         S_STEP: begin
            mul_a  = tmp_ff;
            mul_b  = {1'b0, dt_ff};
            mul_op = MUL_STEP;
         end
         S_SACC: mul_a = w_ff[i_ff];
         S_GAIN: begin
            mul_a  = {32'd0, gamma_ff};
            mul_b  = {1'b0, dt_ff};
            mul_op = MUL_GAIN;
         end
         S_PROJ: mul_a = s_ff;
         S_CORR: begin
            mul_a  = tmp_ff;
            mul_b  = {1'b0, g_ff};
            mul_op = MUL_CORR;
         end
         S_SQUARE: begin
            mul_a  = a_ff[i_ff];
            mul_b  = {1'b0, a_ff[i_ff][31:0]};
            mul_op = MUL_SQUARE;
         end
         default: mul_op = MUL_PROJ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      l_in     = l_ff;
      n_in     = n_ff;
      zero_in  = zero_ff;
      vrow_in  = vrow_ff;
      vcol_in  = vcol_ff;
      w_in     = w_ff;
      m_in     = m_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      tmp_in   = tmp_ff;
      prod_in  = prod_ff;
      s_in     = s_ff;
      g_in     = g_ff;
      r_in     = r_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      mul_start  = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      l_sum   = l_rd + mul_res;
      acc_sum = acc_ff + mul_res;
      any_high = (|a_ff[0][63:31]) | (|a_ff[1][63:31]) | (|a_ff[2][63:31]);
      any_top  = (|a_ff[0][63:30]) | (|a_ff[1][63:30]) | (|a_ff[2][63:30]);
      q_sat = (div_q > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];

      if (!wait_ff && (state_ff == S_VV || state_ff == S_LEAK || state_ff == S_STEP ||
                       state_ff == S_WACC || state_ff == S_SACC || state_ff == S_GAIN ||
                       state_ff == S_PROJ || state_ff == S_CORR || state_ff == S_SQUARE)) begin
         mul_start = 1'b1;
         wait_in   = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               zero_in = 1'b0;
               if (req_cmd) begin
                  for (int k = 0; k < 9; k++) begin
                     l_in[k] = 48'sd0;
                  end
                  n_in     = init_ff;
                  state_in = S_OUT;
               end else begin
                  vrow_in  = '{req_vel_x, req_vel_y, req_vel_z};
                  vcol_in  = '{req_vel_x, req_vel_y, req_vel_z};
                  i_in     = 2'd0;
                  j_in     = 2'd0;
                  wait_in  = 1'b0;
                  state_in = S_VV;
               end
            end
         end
         S_VV: begin
            if (wait_ff && mul_done) begin
               prod_in  = mul_res;
               wait_in  = 1'b0;
               state_in = S_LEAK;
            end
         end
         S_LEAK: begin
            if (wait_ff && mul_done) begin
               tmp_in   = prod_ff - mul_res;
               wait_in  = 1'b0;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (wait_ff && mul_done) begin
               l_in[kidx] = sat48(l_sum);
               wait_in    = 1'b0;
               if (j_ff == 2'd2) begin
                  j_in = 2'd0;
                  if (i_ff == 2'd2) begin
                     i_in     = 2'd0;
                     acc_in   = 64'd0;
                     state_in = S_WACC;
                  end else begin
                     i_in     = i_ff + 2'd1;
                     state_in = S_VV;
                  end
               end else begin
                  j_in     = j_ff + 2'd1;
                  state_in = S_VV;
               end
            end
         end
         S_WACC: begin
            if (wait_ff && mul_done) begin
               wait_in = 1'b0;
               if (j_ff == 2'd2) begin
                  w_in[i_ff] = acc_sum;
                  acc_in     = 64'd0;
                  j_in       = 2'd0;
                  if (i_ff == 2'd2) begin
                     i_in     = 2'd0;
                     state_in = S_SACC;
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end else begin
                  acc_in = acc_sum;
                  j_in   = j_ff + 2'd1;
               end
            end
         end
         S_SACC: begin
            if (wait_ff && mul_done) begin
               wait_in = 1'b0;
               if (i_ff == 2'd2) begin
                  s_in     = acc_sum;
                  i_in     = 2'd0;
                  state_in = S_GAIN;
               end else begin
                  acc_in = acc_sum;
                  i_in   = i_ff + 2'd1;
               end
            end
         end
         S_GAIN: begin
            if (wait_ff && mul_done) begin
               g_in     = mul_res[31:0];
               wait_in  = 1'b0;
               state_in = S_PROJ;
            end
         end
         S_PROJ: begin
            if (wait_ff && mul_done) begin
               tmp_in   = w_ff[i_ff] - mul_res;
               wait_in  = 1'b0;
               state_in = S_CORR;
            end
         end
         S_CORR: begin
            if (wait_ff && mul_done) begin
               m_in[i_ff] = {{32{n_ff[i_ff][31]}}, n_ff[i_ff]} - mul_res;
               wait_in    = 1'b0;
               if (i_ff == 2'd2) begin
                  state_in = S_MAG;
               end else begin
                  i_in     = i_ff + 2'd1;
                  state_in = S_PROJ;
               end
            end
         end
         S_MAG: begin
            for (int k = 0; k < 3; k++) begin
               a_in[k] = m_ff[k][63] ? (64'd0 - m_ff[k]) : m_ff[k];
            end
            if (m_ff[0] == 64'sd0 && m_ff[1] == 64'sd0 && m_ff[2] == 64'sd0) begin
               zero_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (any_high) begin
               for (int k = 0; k < 3; k++) begin
                  a_in[k] = a_ff[k] >> 1;
               end
            end else if (!any_top) begin
               for (int k = 0; k < 3; k++) begin
                  a_in[k] = a_ff[k] << 1;
               end
            end else begin
               i_in     = 2'd0;
               acc_in   = 64'd0;
               wait_in  = 1'b0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (wait_ff && mul_done) begin
               acc_in  = acc_sum;
               wait_in = 1'b0;
               if (i_ff == 2'd2) begin
                  state_in = S_ROOT;
               end else begin
                  i_in = i_ff + 2'd1;
               end
            end
         end
         S_ROOT: begin
            if (!wait_ff) begin
               sqrt_start = 1'b1;
               wait_in    = 1'b1;
            end else if (sqrt_done) begin
               r_in     = sqrt_root;
               wait_in  = 1'b0;
               i_in     = 2'd0;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (!wait_ff) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (div_done) begin
               n_in[i_ff] = m_ff[i_ff][63] ? (32'd0 - q_sat) : q_sat;
               wait_in    = 1'b0;
               if (i_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  i_in = i_ff + 2'd1;
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
         gamma_ff <= GAMMA_RST;
         beta_ff  <= BETA_RST;
         dt_ff    <= DT_RST;
         init_ff  <= '{INIT_X_RST, INIT_Y_RST, INIT_Z_RST};
         n_ff     <= '{INIT_X_RST, INIT_Y_RST, INIT_Z_RST};
         for (int k = 0; k < 9; k++) begin
            l_ff[k] <= 48'sd0;
         end
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         gamma_ff <= gamma_in;
         beta_ff  <= beta_in;
         dt_ff    <= dt_in;
         init_ff  <= init_in;
         n_ff     <= n_in;
         l_ff     <= l_in;
         zero_ff  <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      vrow_ff <= vrow_in;
      vcol_ff <= vcol_in;
      w_ff    <= w_in;
      m_ff    <= m_in;
      a_ff    <= a_in;
      acc_ff  <= acc_in;
      tmp_ff  <= tmp_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
      g_ff    <= g_in;
      r_ff    <= r_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_OUT);
   assign rsp_normal_x  = n_ff[0];
   assign rsp_normal_y  = n_ff[1];
   assign rsp_normal_z  = n_ff[2];
   assign rsp_zero_norm = zero_ff;

endmodule

// ----- rtl/asne_checker.sv -----
module asne_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_cmd,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_normal_x,
   input logic               rsp_zero_norm
);

   // A stalled result word stays on the port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normal_x) && $stable(rsp_zero_norm))
      else $error("result word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before the result word");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result word is pending");

   a_restart_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd |=> rsp_valid && !rsp_zero_norm)
      else $error("restart did not give its result word on the next cycle");

endmodule

bind adaptive_surface_normal_estimator_unit asne_checker u_asne_checker (.*);
